// ===== hdl/view_volume_cull_tests_defines.svh =====
// Assertion macros shared by the view-volume culling modules.
`ifndef VIEW_VOLUME_CULL_TESTS_DEFINES_SVH
`define VIEW_VOLUME_CULL_TESTS_DEFINES_SVH
// Implication checked at every rising clock edge, disabled in reset.
`define VVC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled in reset.
`define VVC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== hdl/vvc_pkg.sv =====
// Shared types and command codes for the view-volume culling block.
package vvc_pkg;
    typedef enum logic [2:0] {
        CMD_LOAD   = 3'd0,
        CMD_POINT  = 3'd1,
        CMD_SPHERE = 3'd2,
        CMD_CUBE   = 3'd3,
        CMD_CBOX   = 3'd4,
        CMD_MMBOX  = 3'd5
    } cmd_t;

    // Test kinds handed from the front end to the back end.
    typedef enum logic [2:0] {
        KIND_REJECT = 3'd0,
        KIND_POINT  = 3'd1,
        KIND_SPHERE = 3'd2,
        KIND_CUBE   = 3'd3,
        KIND_CBOX   = 3'd4,
        KIND_MMBOX  = 3'd5,
        KIND_LOAD   = 3'd6
    } kind_t;

    localparam int FIELD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
endpackage

// ===== hdl/vvc_front.sv =====
// Front end: accepts transactions, classifies them and queues loads, tests and rejects in order.
module vvc_front
    import vvc_pkg::*;
#(
    parameter int PLANE_COUNT = 6,
    parameter int VALUE_WIDTH = 32,
    parameter int IDX_W       = 3
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [2:0]                    command,
    input  logic [2:0]                    plane_index,
    input  logic [6*FIELD_WIDTH-1:0]      shape,
    input  logic [FIELD_WIDTH-1:0]        offset,
    output logic                          q_valid,
    input  logic                          q_ready,
    output kind_t                         q_kind,
    output logic [IDX_W-1:0]              q_idx,
    output logic [6*VALUE_WIDTH-1:0]      q_shape
);
    localparam int DEPTH = 2;

    kind_t                     kind_reg  [DEPTH];
    logic [IDX_W-1:0]          idx_reg   [DEPTH];
    logic [6*VALUE_WIDTH-1:0]  shape_reg [DEPTH];
    logic                      wr_ptr_reg, rd_ptr_reg;
    logic [1:0]                count_reg;
    logic                      push, pop;
    kind_t                     kind_in;
    logic [6*VALUE_WIDTH-1:0]  shape_in;
    logic                      idx_ok;

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_kind   = kind_reg[rd_ptr_reg];
    assign q_idx    = idx_reg[rd_ptr_reg];
    assign q_shape  = shape_reg[rd_ptr_reg];
    assign idx_ok   = ({1'b0, plane_index} < 4'(PLANE_COUNT));

    // Classify the command and trim each value to VALUE_WIDTH bits.
    // A load carries its offset in the fourth value slot.
    always_comb
    begin
        case (command)
            CMD_LOAD:   kind_in = idx_ok ? KIND_LOAD : KIND_REJECT;
            CMD_POINT:  kind_in = KIND_POINT;
            CMD_SPHERE: kind_in = KIND_SPHERE;
            CMD_CUBE:   kind_in = KIND_CUBE;
            CMD_CBOX:   kind_in = KIND_CBOX;
            CMD_MMBOX:  kind_in = KIND_MMBOX;
            default:    kind_in = KIND_REJECT;
        endcase
        for (int i = 0; i < 6; i++)
            shape_in[i*VALUE_WIDTH +: VALUE_WIDTH] =
                shape[i*FIELD_WIDTH +: VALUE_WIDTH];
        if (command == CMD_LOAD)
            shape_in[3*VALUE_WIDTH +: VALUE_WIDTH] = offset[VALUE_WIDTH-1:0];
    end

    // Queue payload.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            kind_reg[wr_ptr_reg]  <= kind_in;
            idx_reg[wr_ptr_reg]   <= plane_index[IDX_W-1:0];
            shape_reg[wr_ptr_reg] <= shape_in;
        end
    end

    // Queue pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    `include "view_volume_cull_tests_defines.svh"
    `VVC_ASSERT_IMPL(a_no_overflow, clk, rst_n, count_reg == 2'd2, !push, "queue overflow")
    `VVC_ASSERT_IMPL(a_count_range, clk, rst_n, 1'b1, count_reg != 2'd3, "queue count bad")
    `VVC_ASSERT_NEXT(a_hold, clk, rst_n, q_valid && !q_ready && !pop, q_valid, "queue lost entry")
endmodule

// ===== hdl/vvc_back.sv =====
// Back end: applies plane loads in order, tests one plane per cycle over eight corners.
module vvc_back
    import vvc_pkg::*;
#(
    parameter int PLANE_COUNT = 6,
    parameter int VALUE_WIDTH = 32,
    parameter int IDX_W       = 3
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  kind_t                         q_kind,
    input  logic [IDX_W-1:0]              q_idx,
    input  logic [6*VALUE_WIDTH-1:0]      q_shape,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          visible
);
    localparam int VW   = VALUE_WIDTH;
    localparam int PW   = 2*VW + 1;
    localparam int AW   = 2*VW + 5;

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_OUT} state_t;

    logic [4*VW-1:0]          plane_reg [PLANE_COUNT];
    state_t                   state_reg;
    logic [IDX_W-1:0]         pidx_reg;
    kind_t                    kind_reg;
    logic signed [VW:0]       u0_reg [3];
    logic signed [VW:0]       u1_reg [3];
    logic signed [VW:0]       v_reg  [3];
    logic signed [VW:0]       sr_reg;
    logic                     vis_reg;
    logic [4*VW-1:0]          pl;
    logic signed [VW-1:0]     n [3];
    logic signed [AW-1:0]     corner_dist [8];
    logic                     pass;
    logic signed [VW:0]       f [3];
    logic signed [VW:0]       s [3];
    logic                     plane_we;

    // A queued load writes its plane when the back end takes it.
    assign plane_we = (state_reg == ST_IDLE) && q_valid && (q_kind == KIND_LOAD);

    // Plane store, cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PLANE_COUNT; i++)
                plane_reg[i] <= '0;
        end
        else if (plane_we)
            plane_reg[q_idx] <= q_shape[4*VW-1:0];
    end

    // Sign-extend the queued shape values.
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            f[a] = (VW+1)'($signed(q_shape[a*VW +: VW]));
            s[a] = (VW+1)'($signed(q_shape[(a+3)*VW +: VW]));
        end
    end

    // Eight corner distances for the current plane, side by side.
    always_comb
    begin
        pl = plane_reg[pidx_reg];
        for (int a = 0; a < 3; a++)
            n[a] = $signed(pl[a*VW +: VW]);
        for (int k = 0; k < 8; k++)
        begin
            corner_dist[k] = AW'($signed(pl[3*VW +: VW])) <<< FRAC_BITS;
            for (int a = 0; a < 3; a++)
            begin
                if (k[a])
                    corner_dist[k] = corner_dist[k] + AW'(n[a] * (u1_reg[a] + v_reg[a]));
                else
                    corner_dist[k] = corner_dist[k] + AW'(n[a] * (u0_reg[a] - v_reg[a]));
            end
        end
        pass = 1'b0;
        for (int k = 0; k < 8; k++)
        begin
            if (kind_reg == KIND_POINT || kind_reg == KIND_CUBE)
                pass = pass | (corner_dist[k] > 0);
            else
                pass = pass | (corner_dist[k] >= 0);
        end
    end

    assign q_ready   = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign visible   = vis_reg;

    // Sequencer: one plane per cycle, stopping at the last plane.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pidx_reg  <= '0;
            vis_reg   <= 1'b0;
            kind_reg  <= KIND_REJECT;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        kind_reg <= q_kind;
                        pidx_reg <= '0;
                        vis_reg  <= 1'b1;
                        for (int a = 0; a < 3; a++)
                        begin
                            u0_reg[a] <= f[a];
                            u1_reg[a] <= (q_kind == KIND_MMBOX) ? s[a] : f[a];
                            case (q_kind)
                                KIND_CUBE:   v_reg[a] <= s[0];
                                KIND_CBOX:   v_reg[a] <= s[a];
                                default:     v_reg[a] <= '0;
                            endcase
                        end
                        // Loads and unused codes report not visible at once.
                        if (q_kind == KIND_REJECT || q_kind == KIND_LOAD)
                        begin
                            vis_reg   <= 1'b0;
                            state_reg <= ST_OUT;
                        end
                        else
                            state_reg <= ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    if (kind_reg == KIND_POINT || kind_reg == KIND_SPHERE)
                    begin
                        if (kind_reg == KIND_SPHERE)
                        begin
                            // The radius term folds into the point distance.
                            if ((corner_dist[0] + (AW'(sr_reg) <<< FRAC_BITS)) <= 0)
                                vis_reg <= 1'b0;
                        end
                        else if (corner_dist[0] <= 0)
                            vis_reg <= 1'b0;
                    end
                    else if (!pass)
                        vis_reg <= 1'b0;
                    if (pidx_reg == IDX_W'(PLANE_COUNT-1))
                        state_reg <= ST_OUT;
                    else
                        pidx_reg <= pidx_reg + 1'b1;
                end
                ST_OUT:
                begin
                    if (out_ready)
                        state_reg <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // Sphere radius captured when the test is taken.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && q_valid)
            sr_reg <= s[0];
    end

    `include "view_volume_cull_tests_defines.svh"
    `VVC_ASSERT_IMPL(a_idx_range, clk, rst_n, state_reg == ST_RUN, pidx_reg < IDX_W'(PLANE_COUNT), "plane index out of range")
    `VVC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(visible), "result dropped")
    `VVC_ASSERT_IMPL(a_reject, clk, rst_n, out_valid && kind_reg == KIND_REJECT, !visible, "reject visible")
endmodule

// ===== hdl/view_volume_cull_tests.sv =====
// Each test is queued, taken by the back end when idle, evaluated one plane per
// cycle in the run state and held in the output state until accepted; loads and
// unused codes go from idle straight to output. A new item is taken only in idle.
// A two-entry queue parts the front end from the back end.
// Reset (rst_n low, asynchronous) clears the queue, sequencer and all planes.
module view_volume_cull_tests
    import vvc_pkg::*;
#(
    parameter int PLANE_COUNT = 6,
    parameter int VALUE_WIDTH = 32
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    // command[2:0], plane_index[5:3], first_x, first_y, first_z, second_x,
    // second_y, second_z, plane_offset (32 bits each), zero pad to 232 bits.
    input  logic [231:0]  s_tdata,
    output logic          m_tvalid,
    input  logic          m_tready,
    // visible[0], zero pad.
    output logic [7:0]    m_tdata
);
    localparam int IDX_W = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;

    logic                      q_valid, q_ready;
    kind_t                     q_kind;
    logic [IDX_W-1:0]          q_idx;
    logic [6*VALUE_WIDTH-1:0]  q_shape;
    logic                      visible;

    vvc_front #(.PLANE_COUNT(PLANE_COUNT), .VALUE_WIDTH(VALUE_WIDTH), .IDX_W(IDX_W)) u_front
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .command(s_tdata[2:0]), .plane_index(s_tdata[5:3]),
        .shape(s_tdata[197:6]), .offset(s_tdata[229:198]),
        .q_valid(q_valid), .q_ready(q_ready), .q_kind(q_kind), .q_idx(q_idx),
        .q_shape(q_shape)
    );

    vvc_back #(.PLANE_COUNT(PLANE_COUNT), .VALUE_WIDTH(VALUE_WIDTH), .IDX_W(IDX_W)) u_back
    (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_kind(q_kind), .q_idx(q_idx),
        .q_shape(q_shape),
        .out_valid(m_tvalid), .out_ready(m_tready), .visible(visible)
    );

    assign m_tdata = {7'd0, visible};
endmodule

// ===== sim/view_volume_cull_tests_tb.sv =====
// Self-checking testbench for the six-plane view-volume culling block.
module view_volume_cull_tests_tb;
    import vvc_pkg::*;

    localparam int NPLANES     = 6;
    localparam int RANDOM_ITEMS = 1330;
    localparam int STALL_LIMIT = 20000;

    // Listed from the top bit down so that command lands in the lowest bits.
    typedef struct packed {
        logic [31:0] plane_offset;
        logic [31:0] second_z;
        logic [31:0] second_y;
        logic [31:0] second_x;
        logic [31:0] first_z;
        logic [31:0] first_y;
        logic [31:0] first_x;
        logic [2:0]  plane_index;
        logic [2:0]  command;
    } cull_item_t;

    // One row of the directed table; known_vis of 2 means use the predictor.
    typedef struct {
        cull_item_t item;
        int         known_vis;
    } cull_row_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [231:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [7:0]   m_tdata;

    // Planes held by the predictor: nx, ny, nz, d.
    logic signed [31:0] plane_mirror [NPLANES][4];
    logic               visibility_queue [$];
    int                 error_count;
    int                 idle_cycles;
    bit                 sending_done;
    bit                 hold_receiver;
    bit                 timed_out;

    view_volume_cull_tests i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Exact plane distance in Q32.32 for a corner at (x, y, z).
    function automatic logic signed [127:0] plane_distance(int p, logic signed [127:0] x,
                                                           logic signed [127:0] y,
                                                           logic signed [127:0] z);
        logic signed [127:0] acc;
        acc = 128'(plane_mirror[p][3]) * 65536;
        acc += 128'(plane_mirror[p][0]) * x;
        acc += 128'(plane_mirror[p][1]) * y;
        acc += 128'(plane_mirror[p][2]) * z;
        return acc;
    endfunction

    // Visibility of one shape against all planes; also applies loads.
    function automatic logic cull_visible(cull_item_t it);
        logic signed [127:0] f [3];
        logic signed [127:0] lo [3];
        logic signed [127:0] hi [3];
        logic signed [127:0] d;
        logic                vis;
        logic                ok;
        bit                  strict;
        f[0] = 128'($signed(it.first_x));
        f[1] = 128'($signed(it.first_y));
        f[2] = 128'($signed(it.first_z));
        vis = 1'b1;
        if (it.command == CMD_LOAD) begin
            if (it.plane_index < NPLANES) begin
                plane_mirror[it.plane_index][0] = it.first_x;
                plane_mirror[it.plane_index][1] = it.first_y;
                plane_mirror[it.plane_index][2] = it.first_z;
                plane_mirror[it.plane_index][3] = it.plane_offset;
            end
            return 1'b0;
        end
        if (it.command > CMD_MMBOX)
            return 1'b0;
        // Corner ranges per axis for the box-type shapes.
        for (int a = 0; a < 3; a++) begin
            logic signed [127:0] s;
            s = (a == 0) ? 128'($signed(it.second_x)) :
                (a == 1) ? 128'($signed(it.second_y)) : 128'($signed(it.second_z));
            case (it.command)
                CMD_CUBE: begin
                    lo[a] = f[a] - 128'($signed(it.second_x));
                    hi[a] = f[a] + 128'($signed(it.second_x));
                end
                CMD_CBOX: begin
                    lo[a] = f[a] - s;
                    hi[a] = f[a] + s;
                end
                default: begin
                    lo[a] = f[a];
                    hi[a] = s;
                end
            endcase
        end
        strict = (it.command == CMD_CUBE);
        for (int p = 0; p < NPLANES; p++) begin
            d = plane_distance(p, f[0], f[1], f[2]);
            if (it.command == CMD_POINT)
                ok = d > 0;
            else if (it.command == CMD_SPHERE)
                ok = d + 128'($signed(it.second_x)) * 65536 > 0;
            else begin
                ok = 1'b0;
                for (int k = 0; k < 8; k++) begin
                    d = plane_distance(p, k[0] ? hi[0] : lo[0], k[1] ? hi[1] : lo[1],
                                       k[2] ? hi[2] : lo[2]);
                    if (strict ? d > 0 : d >= 0)
                        ok = 1'b1;
                end
            end
            if (!ok)
                vis = 1'b0;
        end
        return vis;
    endfunction

    function automatic logic [31:0] random_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0;
            3, 4, 5: return 32'($signed($urandom_range(0, 40)) - 20) <<< 16;
            6, 7: return 32'($signed($urandom_range(0, 400000)) - 200000);
            default: return $urandom();
        endcase
    endfunction

    // Mostly plane loads and tests with moderate values so the results vary.
    function automatic cull_item_t random_item();
        cull_item_t it;
        int         pick;
        pick = $urandom_range(0, 99);
        it.plane_index = (pick < 25) ? 3'($urandom_range(0, 5)) : 3'($urandom_range(0, 7));
        if (pick < 25)
            it.command = CMD_LOAD;
        else if (pick < 95)
            it.command = 3'($urandom_range(1, 5));
        else
            it.command = 3'($urandom_range(0, 7));
        it.first_x      = random_value();
        it.first_y      = random_value();
        it.first_z      = random_value();
        it.second_x     = random_value();
        it.second_y     = random_value();
        it.second_z     = random_value();
        it.plane_offset = random_value();
        // Small normals keep some planes near unit length.
        if (it.command == CMD_LOAD && $urandom_range(0, 1)) begin
            it.first_x = 32'($signed($urandom_range(0, 131072)) - 65536);
            it.first_y = 32'($signed($urandom_range(0, 131072)) - 65536);
            it.first_z = 32'($signed($urandom_range(0, 131072)) - 65536);
        end
        return it;
    endfunction

    function automatic cull_item_t make_item(logic [2:0] c, logic [2:0] p, int fx, int fy,
                                             int fz, int sx, int sy, int sz, int d);
        cull_item_t it;
        it.command = c;
        it.plane_index = p;
        it.first_x = fx;
        it.first_y = fy;
        it.first_z = fz;
        it.second_x = sx;
        it.second_y = sy;
        it.second_z = sz;
        it.plane_offset = d;
        return it;
    endfunction

    // Sender gap: mostly none or short, sometimes long; valid drops during a gap.
    task automatic sender_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) :
            ($urandom_range(0, 1) ? 0 : $urandom_range(1, 3));
        if (n > 0)
            s_tvalid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    // Offer one transaction and wait until it is accepted.
    task automatic send_item(cull_item_t it, int known_vis);
        logic vis;
        s_tdata  <= 232'(it);
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        vis = cull_visible(it);
        if (known_vis != 2 && vis !== known_vis[0])
            $display("%0t directed table disagrees: expected %0d predicted %0b",
                     $time, known_vis, vis);
        visibility_queue.push_back((known_vis != 2) ? known_vis[0] : vis);
        @(negedge clk);
    endtask

    // Stimulus: directed table, then random transactions.
    initial
    begin
        cull_row_t rows [$];
        rows.push_back('{make_item(CMD_POINT, 0, 0, 0, 0, 0, 0, 0, 0), 0});
        rows.push_back('{make_item(CMD_SPHERE, 0, 0, 0, 0, 65536, 0, 0, 0), 1});
        rows.push_back('{make_item(CMD_CUBE, 0, 0, 0, 0, 65536, 0, 0, 0), 0});
        rows.push_back('{make_item(CMD_CBOX, 0, 0, 0, 0, 0, 0, 0, 0), 1});
        rows.push_back('{make_item(CMD_MMBOX, 0, 0, 0, 0, 0, 0, 0, 0), 1});
        rows.push_back('{make_item(3'd6, 0, 1, 1, 1, 1, 1, 1, 1), 0});
        rows.push_back('{make_item(3'd7, 7, -1, -1, -1, -1, -1, -1, -1), 0});
        rows.push_back('{make_item(CMD_LOAD, 6, 65536, 0, 0, 0, 0, 0, 65536), 0});
        rows.push_back('{make_item(CMD_LOAD, 7, 0, 65536, 0, 0, 0, 0, 65536), 0});
        for (int p = 0; p < NPLANES; p++)
            rows.push_back('{make_item(CMD_LOAD, 3'(p), (p == 0) ? 65536 : 0,
                                       (p == 1) ? 65536 : 0, (p == 2) ? -65536 : 0,
                                       0, 0, 0, 10 * 65536), 0});
        rows.push_back('{make_item(CMD_POINT, 0, 0, 0, 0, 0, 0, 0, 0), 2});
        rows.push_back('{make_item(CMD_SPHERE, 0, -11 * 65536, 0, 0, -65536, 0, 0, 0), 2});
        rows.push_back('{make_item(CMD_CUBE, 0, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                                   32'h7fff_ffff, 0, 0, 0), 2});
        rows.push_back('{make_item(CMD_CBOX, 0, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                                   32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0), 2});
        rows.push_back('{make_item(CMD_MMBOX, 0, -20 * 65536, -20 * 65536, -20 * 65536,
                                   -12 * 65536, 0, 0, 0), 2});
        rows.push_back('{make_item(CMD_LOAD, 5, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                                   -1, -1, -1, 32'h7fff_ffff), 0});
        rows.push_back('{make_item(CMD_POINT, 0, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                                   0, 0, 0, 0), 2});
        rows.push_back('{make_item(CMD_LOAD, 4, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                                   0, 0, 0, 32'h8000_0000), 0});
        rows.push_back('{make_item(CMD_SPHERE, 0, -1, -1, -1, 32'h7fff_ffff, 0, 0, 0), 2});
        s_tvalid = 1'b0;
        s_tdata  = '0;
        sending_done = 1'b0;
        hold_receiver = 1'b0;
        rst_n = 1'b0;
        foreach (plane_mirror[p, w])
            plane_mirror[p][w] = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        foreach (rows[i]) begin
            sender_gap();
            send_item(rows[i].item, rows[i].known_vis);
        end
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == 300)
                hold_receiver = 1'b1;
            if (!$urandom_range(0, 2) || i < 30 || (i > 600 && i < 700))
                ; // back-to-back stretch
            else
                sender_gap();
            send_item(random_item(), 2);
        end
        s_tvalid <= 1'b0;
        sending_done = 1'b1;
    end

    // Receiver: random stalls, plus one long hold-off to back up the block.
    initial
    begin
        int n;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_receiver) begin
                hold_receiver = 1'b0;
                m_tready <= 1'b0;
                repeat (200) @(negedge clk);
            end
            if ($urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3);
                repeat (n) @(negedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // Compare each result transaction with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready) begin
            if (visibility_queue.size() == 0) begin
                $display("%0t unexpected result: expected none actual %0b", $time, m_tdata[0]);
                error_count++;
            end else begin
                logic want;
                want = visibility_queue.pop_front();
                if (m_tdata[0] !== want || m_tdata[7:1] !== 7'd0) begin
                    $display("%0t visible mismatch: expected %0b actual %0b (tdata %h)",
                             $time, want, m_tdata[0], m_tdata);
                    error_count++;
                end
            end
        end
    end

    // Watchdog over cycles without any accepted transaction.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // End of run, either when everything has come back or when the watchdog trips.
    initial
    begin
        error_count = 0;
        idle_cycles = 0;
        timed_out = 1'b0;
        @(posedge clk);
        while (!(sending_done && visibility_queue.size() == 0) && idle_cycles < STALL_LIMIT)
            @(posedge clk);
        if (!(sending_done && visibility_queue.size() == 0))
            timed_out = 1'b1;
        repeat (20) @(posedge clk);
        if (!timed_out && error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
